// ===== hw/rtl/isc_pkg.sv =====
// isc_pkg: types and constants shared by the interpolation search core
// item and result structs, controller command and status structs, codes
// no dependencies
package isc_pkg;

    localparam int KEY_W = 32;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [1:0] RD_LO  = 2'd0;
    localparam logic [1:0] RD_HI  = 2'd1;
    localparam logic [1:0] RD_MID = 2'd2;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] entry_value;
        logic signed [KEY_W-1:0] search_key;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_result;

    typedef struct packed {
        logic       init;
        logic       load_wr;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_alo;
        logic       cap_ahi;
        logic       prep;
        logic       mul;
        logic       div_step;
        logic       mid_calc;
        logic       mid_low;
        logic       cmp;
        logic       report_hit;
        logic       report_miss;
    } t_cmd;

    typedef struct packed {
        logic bounds_ok;
        logic out_of_range;
        logic ends_equal;
        logic key_eq;
    } t_sts;

endpackage

// ===== hw/rtl/isc_ram.sv =====
// isc_ram: generic single write port, single read port memory
// read data registered
// no dependencies
module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/isc_ctrl.sv =====
// isc_ctrl: sequencing state machine of the interpolation search core
// drives datapath commands, reads datapath status
// depends on isc_pkg
module isc_ctrl #(
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  isc_pkg::t_sts i_sts,
    output isc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    localparam int CW = $clog2(IW + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOP  = 4'd1;
    localparam logic [3:0] S_RDHI  = 4'd2;
    localparam logic [3:0] S_GETHI = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MID   = 4'd7;
    localparam logic [3:0] S_RDM   = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    isc_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == isc_pkg::FUNC_SEARCH) begin
                        w_cmd.init = 1'b1;
                        n_state    = S_LOOP;
                    end else begin
                        w_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_LOOP: begin
                if (!i_sts.bounds_ok) begin
                    w_cmd.report_miss = 1'b1;
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = isc_pkg::RD_LO;
                    n_state      = S_RDHI;
                end
            end
            S_RDHI: begin
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_sel  = isc_pkg::RD_HI;
                w_cmd.cap_alo = 1'b1;
                n_state       = S_GETHI;
            end
            S_GETHI: begin
                w_cmd.cap_ahi = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.out_of_range) begin
                    w_cmd.report_miss = 1'b1;
                    n_valid           = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_sts.ends_equal) begin
                    w_cmd.mid_low = 1'b1;
                    n_state       = S_RDM;
                end else begin
                    w_cmd.prep = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_cnt     = CW'(IW - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MID;
                end else begin
                    n_cnt = CW'(r_cnt - 1'b1);
                end
            end
            S_MID: begin
                w_cmd.mid_calc = 1'b1;
                n_state        = S_RDM;
            end
            S_RDM: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = isc_pkg::RD_MID;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (i_sts.key_eq) begin
                    w_cmd.report_hit = 1'b1;
                    n_valid          = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.cmp = 1'b1;
                    n_state   = S_LOOP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/isc_dp.sv =====
// isc_dp: datapath of the interpolation search core
// table memory, bounds, probe multiply, restoring divider, result register
// depends on isc_pkg and isc_ram
module isc_dp #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  isc_pkg::t_item              i_item,
    input  logic [isc_pkg::CNT_W-1:0]   i_count,
    input  isc_pkg::t_cmd               i_cmd,
    output isc_pkg::t_sts               o_sts,
    output isc_pkg::t_result            o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int SW = IW + 2;
    localparam int PW = isc_pkg::KEY_W + IW;
    localparam int KW = isc_pkg::KEY_W;

    logic signed [KW-1:0] r_key, r_alo, r_ahi;
    logic signed [SW-1:0] r_lo, r_hi, r_m;
    logic [KW-1:0]        r_diff, r_den;
    logic [IW-1:0]        r_span, r_q;
    logic [PW-1:0]        r_rem, r_dsh;
    isc_pkg::t_result     r_result;

    logic signed [KW-1:0] w_rdata;
    logic [IW-1:0]        w_raddr;
    logic                 w_we;
    logic signed [SW-1:0] w_hi_init, w_sum;
    logic signed [KW:0]   w_diff, w_den;
    logic [PW-1:0]        w_prod;
    logic                 w_ge;

    assign w_we = i_cmd.load_wr && (32'(i_item.entry_index) < DEPTH);

    always_comb begin
        unique case (i_cmd.rd_sel)
            isc_pkg::RD_LO: w_raddr = r_lo[IW-1:0];
            isc_pkg::RD_HI: w_raddr = r_hi[IW-1:0];
            default:        w_raddr = r_m[IW-1:0];
        endcase
    end

    isc_ram #(
        .WIDTH(KW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(IW'(i_item.entry_index)),
        .i_wdata(i_item.entry_value),
        .i_re   (i_cmd.rd_en),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_hi_init = (32'(i_count) > DEPTH) ? SW'(DEPTH - 1) : SW'(int'(i_count) - 1);
    assign w_diff    = {r_key[KW-1], r_key} - {r_alo[KW-1], r_alo};
    assign w_den     = {r_ahi[KW-1], r_ahi} - {r_alo[KW-1], r_alo};
    assign w_prod    = PW'(r_diff) * PW'(r_span);
    assign w_ge      = (r_rem >= r_dsh);
    assign w_sum     = r_lo + $signed({2'b00, r_q});

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_key <= i_item.search_key;
            r_lo  <= '0;
            r_hi  <= w_hi_init;
        end
        if (i_cmd.cap_alo) begin
            r_alo <= w_rdata;
        end
        if (i_cmd.cap_ahi) begin
            r_ahi <= w_rdata;
        end
        if (i_cmd.prep) begin
            r_diff <= w_diff[KW-1:0];
            r_den  <= w_den[KW-1:0];
            r_span <= IW'(r_hi - r_lo);
        end
        if (i_cmd.mul) begin
            r_rem <= w_prod;
            r_dsh <= PW'(r_den) << (IW - 1);
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= IW'({r_q, w_ge});
        end
        if (i_cmd.mid_calc) begin
            r_m <= (w_sum > r_hi) ? r_hi : w_sum;
        end
        if (i_cmd.mid_low) begin
            r_m <= r_lo;
        end
        if (i_cmd.cmp) begin
            if (r_key > w_rdata) begin
                r_lo <= SW'(r_m + 1);
            end else begin
                r_hi <= SW'(r_m - 1);
            end
        end
        if (i_cmd.report_hit) begin
            r_result.found    <= 1'b1;
            r_result.position <= isc_pkg::IDX_W'(r_m);
        end
        if (i_cmd.report_miss) begin
            r_result.found    <= 1'b0;
            r_result.position <= '0;
        end
    end

    assign o_sts.bounds_ok    = (r_lo <= r_hi);
    assign o_sts.out_of_range = (r_key < r_alo) || (r_key > r_ahi);
    assign o_sts.ends_equal   = (r_alo == r_ahi);
    assign o_sts.key_eq       = (r_key == w_rdata);
    assign o_result           = r_result;

endmodule

// ===== hw/rtl/interpolation_search_core.sv =====
// Interpolation search core. A load item (func 0) writes one table entry in the cycle it is
// accepted and leaves busy low; an index at or beyond DEPTH is dropped. A search item
// (func 1) raises busy and walks entries 0 to count-1, count being the entries_in_use
// register saturated to DEPTH. Each probe reads the low and high end values; a key outside
// them ends the search with a miss. With distinct end values a multiply and a divide give
// the probe index, with equal ones the low bound is probed; that entry is then read and
// compared. The probe cost is set by the single read port of the table memory, read up to
// three times per probe, and by the restoring divider that yields one quotient bit a cycle.
// The number of probes is data dependent: usually a few on evenly spread data, up to count
// on skewed data. The result appears on o_result for exactly one cycle under
// o_result_valid, in the cycle busy falls; it cannot be held off, so the receiver must take
// it then. The table must hold ascending values; entries searched must have been loaded.
// The user must write entries_in_use only while busy is low; the core does not enforce it.
// depends on isc_pkg, isc_ctrl, isc_dp
module interpolation_search_core #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  isc_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic [isc_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                      o_result_valid,
    output isc_pkg::t_result          o_result
);

    localparam int IW = $clog2(DEPTH);

    logic [isc_pkg::CNT_W-1:0] r_count;
    isc_pkg::t_cmd             w_cmd;
    isc_pkg::t_sts             w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= isc_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    isc_ctrl #(
        .IW(IW)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_func (i_item.func),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (busy),
        .o_valid(o_result_valid)
    );

    isc_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_item  (i_item),
        .i_count (r_count),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_result(o_result)
    );

endmodule

// ===== hw/rtl/isc_checker.sv =====
// isc_checker: port-level assertions for interpolation_search_core
// bound to the top level below
// depends on isc_pkg
module isc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input isc_pkg::t_item            i_item,
    input logic                      o_result_valid,
    input isc_pkg::t_result          o_result
);

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.func == isc_pkg::FUNC_SEARCH) |=> busy)
        else $error("search item did not raise busy");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.func == isc_pkg::FUNC_LOAD) |=> !busy && !o_result_valid)
        else $error("load item raised busy or gave a result");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("search ended without a result");

    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $fell(busy))
        else $error("result strobe outside the end of a search");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.found |-> o_result.position == '0)
        else $error("miss result carries a nonzero position");

endmodule

bind interpolation_search_core isc_checker u_isc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_item        (i_item),
    .o_result_valid(o_result_valid),
    .o_result      (o_result)
);

// ===== tb/sv/isc_search_checker.sv =====
// isc_search_checker: watches the item, config and result channels of the
// interpolation search core, predicts each search answer and compares it
// depends on isc_pkg
module isc_search_checker #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  isc_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic [isc_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      i_result_valid,
    input  isc_pkg::t_result          i_result,
    output int                        o_open,
    output int                        o_errors,
    output int                        o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    localparam int PRINT_CAP = 100;

    logic [CNT_W-1:0]        entries_used;
    logic signed [KEY_W-1:0] table_mem [DEPTH];
    t_result                 pending_answers [$];
    t_result                 want;
    int                      errors;
    int                      hits;

    assign o_errors = errors;
    assign o_hits   = hits;

    initial begin
        errors = 0;
        hits   = 0;
        o_open = 0;
    end

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        errors++;
    endtask

    function automatic t_result interpolate_lookup(input logic signed [KEY_W-1:0] key);
        t_result answer;
        int      span;
        int      lo;
        int      hi;
        int      probe;
        longint  alo;
        longint  ahi;
        longint  num;
        longint  den;
        answer = '0;
        span = (int'(entries_used) > DEPTH) ? DEPTH : int'(entries_used);
        lo = 0;
        hi = span - 1;
        while (lo <= hi) begin
            alo = table_mem[lo];
            ahi = table_mem[hi];
            if (longint'(key) < alo || longint'(key) > ahi) begin
                return answer;
            end
            if (ahi == alo) begin
                probe = lo;
            end else begin
                num = (longint'(key) - alo) * longint'(hi - lo);
                den = ahi - alo;
                probe = lo + int'(num / den);
                if (probe > hi) begin
                    probe = hi;
                end
            end
            if (key == table_mem[probe]) begin
                answer.found    = 1'b1;
                answer.position = probe[IDX_W-1:0];
                return answer;
            end
            if (key > table_mem[probe]) begin
                lo = probe + 1;
            end else begin
                hi = probe - 1;
            end
        end
        return answer;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries_used = CNT_RESET;
            pending_answers.delete();
            o_open <= 0;
        end else begin
            if (i_cfg_we) begin
                entries_used = i_cfg_wdata;
            end
            if (i_result_valid) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("result found=%0d position=%0d with no search open",
                                              i_result.found, i_result.position));
                end else begin
                    want = pending_answers.pop_front();
                    if (i_result.found !== want.found) begin
                        report_mismatch($sformatf("found is %0d, expected %0d",
                                                  i_result.found, want.found));
                    end
                    if (i_result.position !== want.position) begin
                        report_mismatch($sformatf("position is %0d, expected %0d",
                                                  i_result.position, want.position));
                    end
                    if (want.found) begin
                        hits++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.func == FUNC_LOAD) begin
                    if (int'(i_item.entry_index) < DEPTH) begin
                        table_mem[i_item.entry_index] = i_item.entry_value;
                    end
                end else begin
                    pending_answers.push_back(interpolate_lookup(i_item.search_key));
                end
            end
            o_open <= pending_answers.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives load and search items and entries_in_use writes into the
// interpolation search core, with isc_search_checker beside it; gives the verdict
// depends on isc_pkg, interpolation_search_core, isc_search_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEM_TARGET = 1750;
    localparam int STALL_LIMIT = 4000;
    localparam int INT_MIN     = -2147483647 - 1;
    localparam int INT_MAX     = 2147483647;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             o_result_valid;
    t_result          o_result;

    int open_searches;
    int errors;
    int hits;

    int shadow_table [DEPTH];
    int cur_count;
    int n_loads;
    int n_searches;
    int n_count_writes;
    int quiet_cycles;
    bit steady;

    interpolation_search_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    isc_search_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_result_valid(o_result_valid),
        .i_result      (o_result),
        .o_open        (open_searches),
        .o_errors      (errors),
        .o_hits        (hits)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (i_rst_n && !((start && !busy) || o_result_valid)) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.func == FUNC_LOAD) begin
            n_loads++;
            shadow_table[it.entry_index] = it.entry_value;
        end else begin
            n_searches++;
        end
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (open_searches != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_entries_in_use(input int value);
        hold_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_count = value;
        n_count_writes++;
    endtask

    task automatic load_entry(input int idx, input int value);
        t_item it;
        it.func        = FUNC_LOAD;
        it.entry_index = idx[IDX_W-1:0];
        it.entry_value = value;
        it.search_key  = $urandom;
        maybe_idle();
        send_item(it);
    endtask

    task automatic search_key(input int key);
        t_item it;
        it.func        = FUNC_SEARCH;
        it.entry_index = IDX_W'($urandom);
        it.entry_value = $urandom;
        it.search_key  = key;
        maybe_idle();
        send_item(it);
    endtask

    // sorted tables of several spreads; now and then an unsorted one
    task automatic fill_table();
        int vals [$];
        int pick;
        int base;
        int step;
        int v;
        bit backward;
        pick     = $urandom_range(99);
        base     = int'($urandom_range(0, 500000000)) - 800000000;
        step     = $urandom_range(1, 100000000);
        backward = 1'($urandom_range(1));
        for (int k = 0; k < DEPTH; k++) begin
            if (pick < 30) begin
                v = $urandom;
            end else if (pick < 50) begin
                v = int'($urandom_range(0, 40)) - 20;
            end else if (pick < 70) begin
                v = base + k * step;
            end else if (pick < 85) begin
                v = (k < 12) ? k : (k - 11) * 200000000;
                v = backward ? base - v : base + v;
            end else if (pick < 93) begin
                v = $urandom;
            end else begin
                v = base;
            end
            vals.push_back(v);
        end
        if (pick < 85 || pick >= 93) begin
            vals.sort();
        end
        if (backward) begin
            for (int k = DEPTH - 1; k >= 0; k--) load_entry(k, vals[k]);
        end else begin
            for (int k = 0; k < DEPTH; k++) load_entry(k, vals[k]);
        end
    endtask

    function automatic int pick_key();
        int r;
        int last;
        r = $urandom_range(99);
        last = (cur_count < 1) ? 0 : ((cur_count > DEPTH) ? DEPTH - 1 : cur_count - 1);
        if (r < 55) return shadow_table[$urandom_range(0, last)];
        if (r < 65) return shadow_table[$urandom_range(0, DEPTH - 1)] + 1;
        if (r < 75) return shadow_table[$urandom_range(0, DEPTH - 1)] - 1;
        if (r < 85) return $urandom;
        if (r < 89) return INT_MIN;
        if (r < 93) return INT_MAX;
        return int'($urandom_range(0, 200)) - 100;
    endfunction

    initial begin
        int directed [DEPTH];
        int counts [7];
        int phase;
        directed = '{INT_MIN, -1000000000, -5000, -7, 0, 3, 3, 3, 100, 4096, 65535,
                     1000000, 50000000, 700000000, 2000000000, INT_MAX};
        counts = '{16, 1, 0, 31, 17, 2, 15};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        quiet_cycles = 0;
        n_loads        = 0;
        n_searches     = 0;
        n_count_writes = 0;
        cur_count      = 16;
        steady         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicates, one entry, empty and oversized counts
        for (int k = 0; k < DEPTH; k++) load_entry(k, directed[k]);
        search_key(INT_MIN);
        search_key(INT_MAX);
        search_key(3);
        search_key(101);
        write_entries_in_use(1);
        search_key(INT_MIN);
        search_key(5);
        write_entries_in_use(0);
        search_key(0);
        write_entries_in_use(31);
        search_key(INT_MAX);

        phase = 0;
        while (n_loads + n_searches < ITEM_TARGET) begin
            steady = (phase >= 4 && phase <= 8);
            write_entries_in_use(phase < 7 ? counts[phase] : $urandom_range(0, 31));
            fill_table();
            repeat ($urandom_range(30, 50)) begin
                if ($urandom_range(99) < 5) begin
                    load_entry($urandom_range(0, DEPTH - 1), $urandom);
                end else begin
                    search_key(pick_key());
                end
                if ($urandom_range(99) < 1) begin
                    hold_until_drained();
                end
            end
            phase++;
        end

        hold_until_drained();
        repeat (50) @(posedge i_clk);
        $display("ran %0d loads and %0d searches (%0d hits) over %0d count settings",
                 n_loads, n_searches, hits, n_count_writes);
        $display("counts included empty, single entry, full and above table size");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
